// ----- sv/etog_pkg.sv -----
// Shared constants, types and helper functions for the escape-time orbit generator.
// Used by etog_mac and escape_time_orbit_generator_core; depends on nothing.
package etog_pkg;

  localparam int FRAC_BITS      = 56;
  localparam int COEF_FRAC_BITS = 28;
  localparam int ITER_LIMIT     = 4096;
  localparam int MIN_ITERS      = 32;

  localparam int VAL_W    = 64;
  localparam int COEF_W   = 32;
  localparam int ACC_W    = 2 * VAL_W + 2;
  localparam int TOT_W    = VAL_W + 8;
  localparam int IDX_W    = 12;
  localparam int MAXIT_W  = 13;
  localparam int BAIL_W   = 32;
  localparam int MODE_W   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W    = $clog2(VAL_W);

  localparam int BAIL_SHIFT = 2 * FRAC_BITS - 16;
  localparam int THR_W      = BAIL_W + BAIL_SHIFT;
  localparam int CMP_W      = (THR_W > ACC_W) ? THR_W : ACC_W;
  localparam int K_SHIFT    = FRAC_BITS - COEF_FRAC_BITS;

  localparam int IN_TDATA_W  = 2 * VAL_W;
  localparam int OUT_TDATA_W = ((2 * VAL_W + IDX_W + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUAD  = 3'd0,
    CFG_LIN   = 3'd1,
    CFG_PARAM = 3'd2,
    CFG_CONST = 3'd3,
    CFG_BAIL  = 3'd4,
    CFG_MODE  = 3'd5,
    CFG_MAXIT = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_e;

  typedef struct packed {
    logic start;
    logic clear;
    logic sub;
    logic wide;
  } mac_cmd_t;

  typedef struct packed {
    logic             ovf;
    logic [VAL_W-1:0] val;
  } sat_t;

  // Saturate a wide signed value to VAL_W bits and flag the overflow.
  function automatic sat_t sat_val(input logic signed [ACC_W-1:0] v);
    sat_t                   r;
    logic [ACC_W-VAL_W:0]   top;
    top = v[ACC_W-1:VAL_W-1];
    if (&top || ~|top) begin
      r.ovf = 1'b0;
      r.val = v[VAL_W-1:0];
    end else begin
      r.ovf = 1'b1;
      r.val = v[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ----- sv/escape_time_orbit_generator_core.sv -----
// Top level of the escape-time orbit generator for z <- Q*w^2 + L*w + P*c + K.
// Depends on etog_pkg and instantiates the bit-serial MAC etog_mac.
module escape_time_orbit_generator_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // c_real [63:0], c_imag [127:64]
  input  logic [etog_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  // op [0]: 0 starts an orbit, 1 advances it
  input  logic [0:0]                            s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // z_real [63:0], z_imag [127:64], point_index [139:128], zero padding above
  output logic [etog_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // escaped [0]
  output logic [0:0]                            m_axis_tuser,
  output logic                                  m_axis_tlast,
  input  logic                                  cfg_we_i,
  input  logic [etog_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [etog_pkg::VAL_W-1:0]            cfg_data_i
);
  // A start transaction loads c and clears z and the iteration count; it
  // produces no output. An advance transaction emits the current point with
  // its index, the escape flag and tlast, then updates z. All products go
  // through one bit-serial multiply-accumulate unit that handles one
  // multiplier bit per cycle, and that unit sets the pace of an advance on a
  // running orbit: two 64-bit squares for the bailout test, three 64-bit
  // products for w^2 and twelve coefficient products of 32 multiplier bits
  // each, with steps to accept, emit, prepare and commit around them. The
  // advance that ends an orbit skips the update, and an advance on a
  // finished orbit only repeats the stored point. Input is taken whenever
  // the core is idle, even while an emitted result is still waiting on the
  // output register. Values are signed Q7.56, coefficients signed Q3.28
  // packed real over imaginary, and any saturation counts as an escape that
  // the next emitted point reports.
  import etog_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EMIT   = 6'b000010,
    S_PREP   = 6'b000100,
    S_ISSUE  = 6'b001000,
    S_WAIT   = 6'b010000,
    S_COMMIT = 6'b100000
  } state_e;

  typedef enum logic [3:0] {
    JOB_MAG = 4'd0,
    JOB_SR  = 4'd1,
    JOB_SI  = 4'd2,
    JOB_T1R = 4'd3,
    JOB_T1I = 4'd4,
    JOB_T2R = 4'd5,
    JOB_T2I = 4'd6,
    JOB_T3R = 4'd7,
    JOB_T3I = 4'd8
  } job_e;

  state_e state_q, state_d;
  job_e   job_q, job_d;
  logic   part_q, part_d;

  // Configuration registers.
  logic [VAL_W-1:0]   quad_q, quad_d, lin_q, lin_d, param_q, param_d, const_q, const_d;
  logic [BAIL_W-1:0]  bail_q, bail_d;
  logic [MODE_W-1:0]  mode_q, mode_d;
  logic [MAXIT_W-1:0] maxit_q, maxit_d;

  // Orbit state.
  logic [VAL_W-1:0] z_re_q, z_re_d, z_im_q, z_im_d, c_re_q, c_re_d, c_im_q, c_im_d;
  logic [IDX_W-1:0] iter_q, iter_d;
  logic             done_q, done_d, esc_q, esc_d;

  // Working registers of one update.
  logic [VAL_W-1:0]        wr_q, wr_d, wi_q, wi_d, sr_q, sr_d, si_q, si_d;
  logic signed [TOT_W-1:0] tot_re_q, tot_re_d, tot_im_q, tot_im_d;
  logic                    ovf_q, ovf_d, pend_esc_q, pend_esc_d, pend_last_q, pend_last_d;

  // Output register.
  logic                   out_valid_q, out_valid_d, out_esc_q, out_esc_d;
  logic                   out_last_q, out_last_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  mac_cmd_t                mac_cmd;
  logic [VAL_W-1:0]        mac_a, mac_b;
  logic                    mac_done;
  logic signed [ACC_W-1:0] mac_acc;

  logic                    accept_in, out_free, above, w_ovf;
  logic [MAXIT_W-1:0]      limit;
  logic [MAXIT_W-1:0]      next_iter;
  logic [CMP_W-1:0]        thr, mag;
  logic [VAL_W-1:0]        w_re, w_im;
  logic signed [TOT_W-1:0] acc_term;
  sat_t                    sat_a, sat_b;

  localparam logic [VAL_W-1:0] SMIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [VAL_W-1:0] SMAX = {1'b0, {(VAL_W-1){1'b1}}};

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept_in     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_esc_q;
  assign m_axis_tlast    = out_last_q;

  // Orbit length clamped to the supported range.
  always_comb begin
    if (maxit_q < MAXIT_W'(MIN_ITERS)) begin
      limit = MAXIT_W'(MIN_ITERS);
    end else if (maxit_q > MAXIT_W'(ITER_LIMIT)) begin
      limit = MAXIT_W'(ITER_LIMIT);
    end else begin
      limit = maxit_q;
    end
  end
  assign next_iter = {1'b0, iter_q} + 1'b1;

  // Bailout test: |z|^2 is exact and nonnegative, compared against the
  // threshold scaled to the square's fraction bits.
  assign thr   = CMP_W'(bail_q) << BAIL_SHIFT;
  assign mag   = CMP_W'($unsigned(mac_acc));
  assign above = mag > thr;

  // Folding of z into w: optional absolute values, then optional conjugate.
  always_comb begin
    w_re  = z_re_q;
    w_im  = z_im_q;
    w_ovf = 1'b0;
    if (mode_q[0] && w_re[VAL_W-1]) begin
      if (w_re == SMIN) begin
        w_re  = SMAX;
        w_ovf = 1'b1;
      end else begin
        w_re = VAL_W'(0) - w_re;
      end
    end
    if (mode_q[1] && w_im[VAL_W-1]) begin
      if (w_im == SMIN) begin
        w_im  = SMAX;
        w_ovf = 1'b1;
      end else begin
        w_im = VAL_W'(0) - w_im;
      end
    end
    if (mode_q[2]) begin
      if (w_im == SMIN) begin
        w_im  = SMAX;
        w_ovf = 1'b1;
      end else begin
        w_im = VAL_W'(0) - w_im;
      end
    end
  end

  // Operand selection for each product of each job. Coefficient products
  // feed the 32-bit coefficient half as the serial multiplier.
  always_comb begin
    mac_a       = z_re_q;
    mac_b       = z_re_q;
    mac_cmd.sub = 1'b0;
    case (job_q)
      JOB_MAG: begin
        mac_a = part_q ? z_im_q : z_re_q;
        mac_b = part_q ? z_im_q : z_re_q;
      end
      JOB_SR: begin
        mac_a       = part_q ? wi_q : wr_q;
        mac_b       = part_q ? wi_q : wr_q;
        mac_cmd.sub = part_q;
      end
      JOB_SI: begin
        mac_a = wr_q;
        mac_b = wi_q;
      end
      JOB_T1R: begin
        mac_a       = part_q ? si_q : sr_q;
        mac_b       = part_q ? VAL_W'(quad_q[COEF_W-1:0]) : VAL_W'(quad_q[VAL_W-1:COEF_W]);
        mac_cmd.sub = part_q;
      end
      JOB_T1I: begin
        mac_a = part_q ? sr_q : si_q;
        mac_b = part_q ? VAL_W'(quad_q[COEF_W-1:0]) : VAL_W'(quad_q[VAL_W-1:COEF_W]);
      end
      JOB_T2R: begin
        mac_a       = part_q ? wi_q : wr_q;
        mac_b       = part_q ? VAL_W'(lin_q[COEF_W-1:0]) : VAL_W'(lin_q[VAL_W-1:COEF_W]);
        mac_cmd.sub = part_q;
      end
      JOB_T2I: begin
        mac_a = part_q ? wr_q : wi_q;
        mac_b = part_q ? VAL_W'(lin_q[COEF_W-1:0]) : VAL_W'(lin_q[VAL_W-1:COEF_W]);
      end
      JOB_T3R: begin
        mac_a       = part_q ? c_im_q : c_re_q;
        mac_b       = part_q ? VAL_W'(param_q[COEF_W-1:0]) : VAL_W'(param_q[VAL_W-1:COEF_W]);
        mac_cmd.sub = part_q;
      end
      JOB_T3I: begin
        mac_a = part_q ? c_re_q : c_im_q;
        mac_b = part_q ? VAL_W'(param_q[COEF_W-1:0]) : VAL_W'(param_q[VAL_W-1:COEF_W]);
      end
      default: begin
        mac_a = z_re_q;
        mac_b = z_re_q;
      end
    endcase
    mac_cmd.wide  = (job_q == JOB_MAG) || (job_q == JOB_SR) || (job_q == JOB_SI);
    mac_cmd.start = (state_q == S_ISSUE);
    mac_cmd.clear = !part_q;
  end

  // Saturation and scaling of the accumulator at the end of each job.
  always_comb begin
    sat_a    = sat_val(mac_acc >>> FRAC_BITS);
    sat_b    = sat_val(mac_acc >>> (FRAC_BITS - 1));
    acc_term = TOT_W'(mac_acc >>> COEF_FRAC_BITS);
  end

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    part_d      = part_q;
    quad_d      = quad_q;
    lin_d       = lin_q;
    param_d     = param_q;
    const_d     = const_q;
    bail_d      = bail_q;
    mode_d      = mode_q;
    maxit_d     = maxit_q;
    z_re_d      = z_re_q;
    z_im_d      = z_im_q;
    c_re_d      = c_re_q;
    c_im_d      = c_im_q;
    iter_d      = iter_q;
    done_d      = done_q;
    esc_d       = esc_q;
    wr_d        = wr_q;
    wi_d        = wi_q;
    sr_d        = sr_q;
    si_d        = si_q;
    tot_re_d    = tot_re_q;
    tot_im_d    = tot_im_q;
    ovf_d       = ovf_q;
    pend_esc_d  = pend_esc_q;
    pend_last_d = pend_last_q;
    out_valid_d = out_valid_q;
    out_esc_d   = out_esc_q;
    out_last_d  = out_last_q;
    out_data_d  = out_data_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_QUAD:  quad_d  = cfg_data_i;
        CFG_LIN:   lin_d   = cfg_data_i;
        CFG_PARAM: param_d = cfg_data_i;
        CFG_CONST: const_d = cfg_data_i;
        CFG_BAIL:  bail_d  = cfg_data_i[BAIL_W-1:0];
        CFG_MODE:  mode_d  = cfg_data_i[MODE_W-1:0];
        CFG_MAXIT: maxit_d = cfg_data_i[MAXIT_W-1:0];
        default: begin
        end
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (accept_in) begin
          if (op_e'(s_axis_tuser[0]) == OP_START) begin
            c_re_d = s_axis_tdata[VAL_W-1:0];
            c_im_d = s_axis_tdata[IN_TDATA_W-1:VAL_W];
            z_re_d = '0;
            z_im_d = '0;
            iter_d = '0;
            done_d = 1'b0;
            esc_d  = 1'b0;
          end else if (done_q) begin
            // Finished orbit: repeat the stored point.
            pend_esc_d  = esc_q;
            pend_last_d = 1'b1;
            state_d     = S_EMIT;
          end else begin
            job_d   = JOB_MAG;
            part_d  = 1'b0;
            state_d = S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (mac_done) begin
          if (!part_q && (job_q != JOB_SI)) begin
            part_d  = 1'b1;
            state_d = S_ISSUE;
          end else begin
            part_d  = 1'b0;
            state_d = S_ISSUE;
            case (job_q)
              JOB_MAG: begin
                esc_d      = esc_q || above;
                pend_esc_d = esc_q || above;
                if (esc_q || above || (next_iter >= limit)) begin
                  done_d      = 1'b1;
                  pend_last_d = 1'b1;
                end else begin
                  pend_last_d = 1'b0;
                end
                state_d = S_EMIT;
              end
              JOB_SR: begin
                sr_d  = sat_a.val;
                ovf_d = ovf_q | sat_a.ovf;
                job_d = JOB_SI;
              end
              JOB_SI: begin
                si_d  = sat_b.val;
                ovf_d = ovf_q | sat_b.ovf;
                job_d = JOB_T1R;
              end
              JOB_T1R: begin
                tot_re_d = tot_re_q + acc_term;
                job_d    = JOB_T1I;
              end
              JOB_T1I: begin
                tot_im_d = tot_im_q + acc_term;
                job_d    = JOB_T2R;
              end
              JOB_T2R: begin
                tot_re_d = tot_re_q + acc_term;
                job_d    = JOB_T2I;
              end
              JOB_T2I: begin
                tot_im_d = tot_im_q + acc_term;
                job_d    = JOB_T3R;
              end
              JOB_T3R: begin
                tot_re_d = tot_re_q + acc_term;
                job_d    = JOB_T3I;
              end
              JOB_T3I: begin
                tot_im_d = tot_im_q + acc_term;
                state_d  = S_COMMIT;
              end
              default: begin
                state_d = S_IDLE;
              end
            endcase
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = OUT_TDATA_W'({iter_q, z_im_q, z_re_q});
          out_esc_d   = pend_esc_q;
          out_last_d  = pend_last_q;
          state_d     = pend_last_q ? S_IDLE : S_PREP;
        end
      end
      S_PREP: begin
        wr_d  = w_re;
        wi_d  = w_im;
        ovf_d = w_ovf;
        // The additive constant, rescaled to the value format, seeds the sums.
        tot_re_d = TOT_W'($signed(const_q[VAL_W-1:COEF_W])) <<< K_SHIFT;
        tot_im_d = TOT_W'($signed(const_q[COEF_W-1:0])) <<< K_SHIFT;
        job_d    = JOB_SR;
        part_d   = 1'b0;
        state_d  = S_ISSUE;
      end
      S_COMMIT: begin
        z_re_d = sat_val(ACC_W'(tot_re_q)).val;
        z_im_d = sat_val(ACC_W'(tot_im_q)).val;
        if (ovf_q || sat_val(ACC_W'(tot_re_q)).ovf || sat_val(ACC_W'(tot_im_q)).ovf) begin
          esc_d = 1'b1;
        end
        iter_d  = next_iter[IDX_W-1:0];
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      job_q       <= JOB_MAG;
      part_q      <= 1'b0;
      quad_q      <= VAL_W'(64'd1 << (COEF_W + COEF_FRAC_BITS));
      lin_q       <= '0;
      param_q     <= VAL_W'(64'd1 << (COEF_W + COEF_FRAC_BITS));
      const_q     <= '0;
      bail_q      <= BAIL_W'(262144);
      mode_q      <= '0;
      maxit_q     <= MAXIT_W'(ITER_LIMIT);
      z_re_q      <= '0;
      z_im_q      <= '0;
      c_re_q      <= '0;
      c_im_q      <= '0;
      iter_q      <= '0;
      done_q      <= 1'b0;
      esc_q       <= 1'b0;
      ovf_q       <= 1'b0;
      pend_esc_q  <= 1'b0;
      pend_last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      job_q       <= job_d;
      part_q      <= part_d;
      quad_q      <= quad_d;
      lin_q       <= lin_d;
      param_q     <= param_d;
      const_q     <= const_d;
      bail_q      <= bail_d;
      mode_q      <= mode_d;
      maxit_q     <= maxit_d;
      z_re_q      <= z_re_d;
      z_im_q      <= z_im_d;
      c_re_q      <= c_re_d;
      c_im_q      <= c_im_d;
      iter_q      <= iter_d;
      done_q      <= done_d;
      esc_q       <= esc_d;
      ovf_q       <= ovf_d;
      pend_esc_q  <= pend_esc_d;
      pend_last_q <= pend_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_q       <= wr_d;
    wi_q       <= wi_d;
    sr_q       <= sr_d;
    si_q       <= si_d;
    tot_re_q   <= tot_re_d;
    tot_im_q   <= tot_im_d;
    out_esc_q  <= out_esc_d;
    out_last_q <= out_last_d;
    out_data_q <= out_data_d;
  end

  etog_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mac_cmd),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .done_o (mac_done),
    .acc_o  (mac_acc)
  );

endmodule

// ----- sv/etog_mac.sv -----
// Bit-serial signed multiply-accumulate unit: one multiplier bit per cycle.
// Depends on etog_pkg for widths and the command struct.
module etog_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  etog_pkg::mac_cmd_t                  cmd_i,
  input  logic [etog_pkg::VAL_W-1:0]          a_i,
  input  logic [etog_pkg::VAL_W-1:0]          b_i,
  output logic                                done_o,
  output logic signed [etog_pkg::ACC_W-1:0]   acc_o
);
  import etog_pkg::*;

  logic signed [ACC_W-1:0] acc_q, acc_d, mcand_q, mcand_d;
  logic [VAL_W-1:0]        mplier_q, mplier_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    busy_q, busy_d, done_q, done_d;
  logic                    sub_q, sub_d, wide_q, wide_d;
  logic                    last_step, neg;

  always_comb begin
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    sub_d    = sub_q;
    wide_d   = wide_q;
    done_d   = 1'b0;
    // The top multiplier bit carries negative weight.
    last_step = wide_q ? (cnt_q == CNT_W'(VAL_W - 1)) : (cnt_q == CNT_W'(COEF_W - 1));
    neg       = sub_q ^ last_step;
    if (cmd_i.start) begin
      mcand_d  = ACC_W'($signed(a_i));
      mplier_d = b_i;
      cnt_d    = '0;
      busy_d   = 1'b1;
      sub_d    = cmd_i.sub;
      wide_d   = cmd_i.wide;
      if (cmd_i.clear) begin
        acc_d = '0;
      end
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_d = neg ? (acc_q - mcand_q) : (acc_q + mcand_q);
      end
      mcand_d  = mcand_q <<< 1;
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q + 1'b1;
      if (last_step) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      sub_q  <= 1'b0;
      wide_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      sub_q  <= sub_d;
      wide_q <= wide_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule
